// File: rtl/tlec_pkg.sv
// shared types and constants for the two-line exchange controller
// no dependencies

package tlec_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_SEIZE_DELAY   = 3'd0;
	localparam logic [2:0] REG_RELEASE_GUARD = 3'd1;
	localparam logic [2:0] REG_RING_ON_TIME  = 3'd2;
	localparam logic [2:0] REG_RING_PERIOD   = 3'd3;
	localparam logic [2:0] REG_POLARITY_HALF = 3'd4;

	localparam logic [15:0] SEIZE_DELAY_RST   = 16'd300;
	localparam logic [15:0] RELEASE_GUARD_RST = 16'd500;
	localparam logic [15:0] RING_ON_TIME_RST  = 16'd1000;
	localparam logic [15:0] RING_PERIOD_RST   = 16'd3000;
	localparam logic [7:0]  POLARITY_HALF_RST = 8'd25;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SEIZE_A   = 3'd1;
	localparam logic [2:0] ST_SEIZE_B   = 3'd2;
	localparam logic [2:0] ST_RING_A    = 3'd3;
	localparam logic [2:0] ST_RING_B    = 3'd4;
	localparam logic [2:0] ST_CONNECTED = 3'd5;
	localparam logic [2:0] ST_GUARD     = 3'd6;

	typedef struct packed {
		logic hook_a;
		logic hook_b;
		logic ms_advance;
	} tlec_poll_t;

	typedef struct packed {
		logic       line_relay;
		logic       ring_enable;
		logic       ring_polarity;
		logic [2:0] exchange_state;
	} tlec_result_t;

	typedef struct packed {
		logic [15:0] seize_delay;
		logic [15:0] release_guard;
		logic [15:0] ring_on_time;
		logic [15:0] ring_period;
		logic [7:0]  polarity_half;
	} tlec_cfg_t;

endpackage

// File: rtl/tlec_regs.sv
// apb configuration registers of the two-line exchange controller
// depends on tlec_pkg

module tlec_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlec_pkg::ADDR_W-1:0]   paddr,
	input  logic [tlec_pkg::DATA_W-1:0]   pwdata,
	output logic [tlec_pkg::DATA_W-1:0]   prdata,
	output tlec_pkg::tlec_cfg_t           cfg
);
	import tlec_pkg::*;

	tlec_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seize_delay   <= SEIZE_DELAY_RST;
			cfg_q.release_guard <= RELEASE_GUARD_RST;
			cfg_q.ring_on_time  <= RING_ON_TIME_RST;
			cfg_q.ring_period   <= RING_PERIOD_RST;
			cfg_q.polarity_half <= POLARITY_HALF_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SEIZE_DELAY:   cfg_q.seize_delay   <= pwdata[15:0];
				REG_RELEASE_GUARD: cfg_q.release_guard <= pwdata[15:0];
				REG_RING_ON_TIME:  cfg_q.ring_on_time  <= pwdata[15:0];
				REG_RING_PERIOD:   cfg_q.ring_period   <= pwdata[15:0];
				REG_POLARITY_HALF: cfg_q.polarity_half <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SEIZE_DELAY:   prdata = {16'd0, cfg_q.seize_delay};
			REG_RELEASE_GUARD: prdata = {16'd0, cfg_q.release_guard};
			REG_RING_ON_TIME:  prdata = {16'd0, cfg_q.ring_on_time};
			REG_RING_PERIOD:   prdata = {16'd0, cfg_q.ring_period};
			REG_POLARITY_HALF: prdata = {24'd0, cfg_q.polarity_half};
			default:           prdata = '0;
		endcase
	end

endmodule

// File: rtl/two_line_exchange_controller.sv
// two-line exchange controller: poll register, state update, result register
// depends on tlec_pkg and tlec_regs
// a poll passes the poll register and then the result register; a stalled result holds it back
// throughput: one poll per cycle while no result is stalled, set by the single state update
// reset: state idle, timers and polarity cleared, registers at their defaults, no result held

module two_line_exchange_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          poll_valid,
	output logic                          poll_stall,
	input  tlec_pkg::tlec_poll_t          poll,
	output logic                          result_valid,
	input  logic                          result_stall,
	output tlec_pkg::tlec_result_t        result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlec_pkg::ADDR_W-1:0]   paddr,
	input  logic [tlec_pkg::DATA_W-1:0]   pwdata,
	output logic [tlec_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import tlec_pkg::*;

	typedef enum logic [2:0] {
		IDLE      = ST_IDLE,
		SEIZE_A   = ST_SEIZE_A,
		SEIZE_B   = ST_SEIZE_B,
		RING_A    = ST_RING_A,
		RING_B    = ST_RING_B,
		CONNECTED = ST_CONNECTED,
		GUARD     = ST_GUARD
	} state_t;

	tlec_cfg_t    cfg;
	tlec_poll_t   poll_s1;
	logic         valid_s1;
	tlec_result_t result_q;
	logic         result_valid_q;
	logic         advance;

	state_t       state_q, state_n;
	logic [15:0]  elapsed_q, elapsed_t, elapsed_n;
	logic [15:0]  phase_q, phase_t, phase_n;
	logic [7:0]   pcount_q, pcount_n;
	logic         pbit_q, pbit_n;
	logic         tick, go, pol_wrap, ringing;
	logic [16:0]  phase_sum;
	logic [8:0]   pcount_sum;
	logic         a, b;

	tlec_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready       = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign poll_stall   = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign a    = poll_s1.hook_a;
	assign b    = poll_s1.hook_b;
	assign tick = poll_s1.ms_advance;

	always_comb begin
		elapsed_t  = (tick && elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
		phase_sum  = {1'b0, phase_q} + 17'd1;
		phase_t    = phase_q;
		if (tick) begin
			phase_t = (phase_sum >= {1'b0, cfg.ring_period}) ? 16'd0 : phase_sum[15:0];
		end
		pcount_sum = {1'b0, pcount_q} + 9'd1;
		pol_wrap   = pcount_sum >= {1'b0, cfg.polarity_half};
		pcount_n   = pcount_q;
		pbit_n     = pbit_q;
		if (tick) begin
			pcount_n = pol_wrap ? 8'd0 : pcount_sum[7:0];
			pbit_n   = pbit_q ^ pol_wrap;
		end

		go      = 1'b0;
		state_n = state_q;
		case (state_q)
			SEIZE_A: begin
				if (!a) begin
					go = 1'b1; state_n = GUARD;
				end else if (elapsed_t >= cfg.seize_delay) begin
					go = 1'b1; state_n = RING_B;
				end
			end
			SEIZE_B: begin
				if (!b) begin
					go = 1'b1; state_n = GUARD;
				end else if (elapsed_t >= cfg.seize_delay) begin
					go = 1'b1; state_n = RING_A;
				end
			end
			RING_A, RING_B: begin
				if (!a && !b) begin
					go = 1'b1; state_n = GUARD;
				end else if (a && b) begin
					go = 1'b1; state_n = CONNECTED;
				end
			end
			CONNECTED: begin
				if (!a || !b) begin
					go = 1'b1; state_n = GUARD;
				end
			end
			GUARD: begin
				if (elapsed_t >= cfg.release_guard && !a && !b) begin
					go = 1'b1; state_n = IDLE;
				end
			end
			default: begin
				if (a && !b) begin
					go = 1'b1; state_n = SEIZE_A;
				end else if (b && !a) begin
					go = 1'b1; state_n = SEIZE_B;
				end
			end
		endcase

		elapsed_n = go ? 16'd0 : elapsed_t;
		phase_n   = go ? 16'd0 : phase_t;
		ringing   = (state_n == RING_A) || (state_n == RING_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			state_q        <= IDLE;
			elapsed_q      <= '0;
			phase_q        <= '0;
			pcount_q       <= '0;
			pbit_q         <= 1'b0;
		end else begin
			if (!poll_stall) begin
				valid_s1 <= poll_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q   <= state_n;
					elapsed_q <= elapsed_n;
					phase_q   <= phase_n;
					pcount_q  <= pcount_n;
					pbit_q    <= pbit_n;
					result_q.line_relay     <= state_n == CONNECTED;
					result_q.ring_enable    <= ringing && (phase_n < cfg.ring_on_time);
					result_q.ring_polarity  <= pbit_n;
					result_q.exchange_state <= state_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!poll_stall) begin
			poll_s1 <= poll;
		end
	end

endmodule

// File: rtl/tlec_checker.sv
// port-level checks for the two-line exchange controller, bound to the top level
// depends on tlec_pkg and two_line_exchange_controller

module tlec_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_stall,
	input tlec_pkg::tlec_result_t result
);
	import tlec_pkg::*;

	// held result stays put until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.line_relay == (result.exchange_state == ST_CONNECTED))
		else $error("line relay does not follow connected state");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.ring_enable |->
			(result.exchange_state == ST_RING_A || result.exchange_state == ST_RING_B))
		else $error("ring enabled outside ringing");

	// connect only from ringing or while already connected
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall ##1 result_valid &&
			result.exchange_state == ST_CONNECTED |->
			($past(result.exchange_state) == ST_RING_A ||
			 $past(result.exchange_state) == ST_RING_B ||
			 $past(result.exchange_state) == ST_CONNECTED))
		else $error("connected without ringing");

endmodule

bind two_line_exchange_controller tlec_checker u_tlec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: tb/sv/two_line_exchange_controller_test.sv
// self-checking testbench for the two-line exchange controller: directed table, then random polls
// in register phases, checked against an in-line model of the exchange; depends on tlec_pkg

module two_line_exchange_controller_test;
	import tlec_pkg::*;

	localparam int DIR_ROWS       = 38;
	localparam int PHASES         = 7;
	localparam int PHASE_ITEMS    = 200;
	localparam int PH_MAX         = 1;
	localparam int PH_MIN         = 2;
	localparam int PH_PRESSURE    = 3;
	localparam int LONG_HOLD      = 150;
	localparam int WATCHDOG_LIMIT = 1000;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_POLL, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [2:0]   idx;
		logic [31:0]  value;
		tlec_poll_t   p;
		logic         typed;
		tlec_result_t res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                poll_valid;
	logic                poll_stall;
	tlec_poll_t          poll;
	logic                result_valid;
	logic                result_stall;
	tlec_result_t        result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic [15:0] cfg_seize_delay   = SEIZE_DELAY_RST;
	logic [15:0] cfg_release_guard = RELEASE_GUARD_RST;
	logic [15:0] cfg_ring_on_time  = RING_ON_TIME_RST;
	logic [15:0] cfg_ring_period   = RING_PERIOD_RST;
	logic [7:0]  cfg_polarity_half = POLARITY_HALF_RST;

	logic [2:0]  exch_state = ST_IDLE;
	logic [15:0] state_ms   = '0;
	logic [15:0] ring_ms    = '0;
	logic [7:0]  rev_count  = '0;
	logic        rev_bit    = 1'b0;

	tlec_result_t pending_results [$];
	tlec_result_t want;

	logic       lift_a = 1'b0;
	logic       lift_b = 1'b0;
	logic       idle_on = 1'b1;
	logic       long_hold_req = 1'b0;
	int         hold_left = 0;
	int         quiet_cycles = 0;
	int         mismatch_count = 0;
	int         polls_sent = 0;
	int         results_checked = 0;
	int         reg_writes = 0;
	logic [7:0] states_seen = '0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_REG,  REG_SEIZE_DELAY,   32'd1,         3'b000, 1'b0, '0},
		'{ROW_REG,  REG_RELEASE_GUARD, 32'd2,         3'b000, 1'b0, '0},
		'{ROW_REG,  REG_RING_ON_TIME,  32'd3,         3'b000, 1'b0, '0},
		'{ROW_REG,  REG_RING_PERIOD,   32'd4,         3'b000, 1'b0, '0},
		'{ROW_REG,  REG_POLARITY_HALF, 32'd0,         3'b000, 1'b0, '0},
		'{ROW_REG,  REG_SPARE_LO,      32'hFFFF_FFFF, 3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b110, 1'b1, {3'b000, ST_IDLE}},
		'{ROW_POLL, '0, '0, 3'b000, 1'b1, {3'b000, ST_IDLE}},
		'{ROW_POLL, '0, '0, 3'b100, 1'b1, {3'b000, ST_SEIZE_A}},
		'{ROW_POLL, '0, '0, 3'b101, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b101, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b101, 1'b0, '0},
		'{ROW_REG,  REG_RING_PERIOD,   32'd2,         3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b100, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b101, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b111, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b111, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b010, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b011, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b001, 1'b0, '0},
		'{ROW_REG,  REG_RING_PERIOD,   32'd0,         3'b000, 1'b0, '0},
		'{ROW_REG,  REG_POLARITY_HALF, 32'd5,         3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b010, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b011, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b011, 1'b0, '0},
		'{ROW_REG,  REG_POLARITY_HALF, 32'd1,         3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b011, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b101, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b001, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b100, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b001, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b001, 1'b0, '0},
		'{ROW_REG,  REG_SPARE_HI,      32'h0000_1234, 3'b000, 1'b0, '0},
		'{ROW_REG,  REG_SEIZE_DELAY,   32'hABCD_FFFF, 3'b000, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b011, 1'b0, '0},
		'{ROW_POLL, '0, '0, 3'b001, 1'b0, '0}
	};

	two_line_exchange_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_stall   (poll_stall),
		.poll         (poll),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic tlec_result_t next_exchange_result(input tlec_poll_t p);
		tlec_result_t r;
		logic [2:0]   target;
		int           nx;
		if (p.ms_advance) begin
			if (state_ms != 16'hFFFF)
				state_ms = state_ms + 16'd1;
			nx = int'(ring_ms) + 1;
			ring_ms = (nx >= int'(cfg_ring_period)) ? 16'd0 : nx[15:0];
			nx = int'(rev_count) + 1;
			if (nx >= int'(cfg_polarity_half)) begin
				rev_count = 8'd0;
				rev_bit = ~rev_bit;
			end else begin
				rev_count = nx[7:0];
			end
		end
		target = exch_state;
		case (exch_state)
			ST_SEIZE_A: begin
				if (!p.hook_a)
					target = ST_GUARD;
				else if (state_ms >= cfg_seize_delay)
					target = ST_RING_B;
			end
			ST_SEIZE_B: begin
				if (!p.hook_b)
					target = ST_GUARD;
				else if (state_ms >= cfg_seize_delay)
					target = ST_RING_A;
			end
			ST_RING_A, ST_RING_B: begin
				if (!p.hook_a && !p.hook_b)
					target = ST_GUARD;
				else if (p.hook_a && p.hook_b)
					target = ST_CONNECTED;
			end
			ST_CONNECTED: begin
				if (!p.hook_a || !p.hook_b)
					target = ST_GUARD;
			end
			ST_GUARD: begin
				if (state_ms >= cfg_release_guard && !p.hook_a && !p.hook_b)
					target = ST_IDLE;
			end
			default: begin
				if (p.hook_a && !p.hook_b)
					target = ST_SEIZE_A;
				else if (p.hook_b && !p.hook_a)
					target = ST_SEIZE_B;
			end
		endcase
		if (target != exch_state) begin
			exch_state = target;
			state_ms = '0;
			ring_ms = '0;
		end
		r.line_relay = (exch_state == ST_CONNECTED);
		r.ring_enable = (exch_state == ST_RING_A || exch_state == ST_RING_B) &&
			(ring_ms < cfg_ring_on_time);
		r.ring_polarity = rev_bit;
		r.exchange_state = exch_state;
		return r;
	endfunction

	// mostly callers who hold a hook level for a while, some random noise
	function automatic tlec_poll_t user_poll();
		tlec_poll_t p;
		if ($urandom_range(0, 9) == 0) begin
			p = 3'($urandom_range(0, 7));
		end else begin
			if ($urandom_range(0, 7) == 0)
				lift_a = ~lift_a;
			if ($urandom_range(0, 7) == 0)
				lift_b = ~lift_b;
			p.hook_a = lift_a;
			p.hook_b = lift_b;
			p.ms_advance = ($urandom_range(0, 3) != 0);
		end
		return p;
	endfunction

	function automatic logic [31:0] phase_reg_value(input int phase, input logic [2:0] idx);
		logic [31:0] mask;
		logic [31:0] v;
		int          roll;
		mask = (idx == REG_POLARITY_HALF) ? 32'h0000_00FF : 32'h0000_FFFF;
		roll = $urandom_range(0, 7);
		if (phase == PH_MAX || (phase != PH_MIN && roll == 0)) begin
			v = mask;
		end else if (phase == PH_MIN || roll == 1) begin
			v = (idx == REG_RING_PERIOD || idx == REG_POLARITY_HALF) ? 32'd1 : 32'd0;
		end else begin
			case (idx)
				REG_RING_ON_TIME:  v = $urandom_range(0, 6);
				REG_RING_PERIOD:   v = $urandom_range(1, 8);
				REG_POLARITY_HALF: v = $urandom_range(1, 6);
				default:           v = $urandom_range(0, 12);
			endcase
		end
		return v | ($urandom() & ~mask);
	endfunction

	task automatic send_poll(input tlec_poll_t p, input logic typed, input tlec_result_t given);
		tlec_result_t predicted;
		int           gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
		if (gap > 0) begin
			poll_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll <= p;
		poll_valid <= 1'b1;
		do @(posedge clk); while (poll_stall);
		predicted = next_exchange_result(p);
		pending_results.push_back(typed ? given : predicted);
		polls_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		poll_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_POLARITY_HALF) ? 32'h0000_00FF : 32'h0000_FFFF;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SEIZE_DELAY:   cfg_seize_delay = value[15:0];
			REG_RELEASE_GUARD: cfg_release_guard = value[15:0];
			REG_RING_ON_TIME:  cfg_ring_on_time = value[15:0];
			REG_RING_PERIOD:   cfg_ring_period = value[15:0];
			REG_POLARITY_HALF: cfg_polarity_half = value[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		if (idx <= REG_POLARITY_HALF) begin
			pwrite <= 1'b0;
			penable <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if ((prdata & mask) != (value & mask)) begin
				$error("register %0d: expected %0h, actual %0h", idx, value & mask,
					prdata & mask);
				mismatch_count++;
			end
			@(negedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// receiver side: random stall bursts, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			result_stall <= 1'b1;
			hold_left = LONG_HOLD - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			hold_left = $urandom_range(0, 15);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no poll outstanding: %0h", result);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.line_relay !== want.line_relay) begin
					$error("line_relay: expected %0d, actual %0d", want.line_relay,
						result.line_relay);
					mismatch_count++;
				end
				if (result.ring_enable !== want.ring_enable) begin
					$error("ring_enable: expected %0d, actual %0d", want.ring_enable,
						result.ring_enable);
					mismatch_count++;
				end
				if (result.ring_polarity !== want.ring_polarity) begin
					$error("ring_polarity: expected %0d, actual %0d", want.ring_polarity,
						result.ring_polarity);
					mismatch_count++;
				end
				if (result.exchange_state !== want.exchange_state) begin
					$error("exchange_state: expected %0d, actual %0d", want.exchange_state,
						result.exchange_state);
					mismatch_count++;
				end
				states_seen[result.exchange_state] = 1'b1;
				results_checked++;
			end
		end
		if ((poll_valid && !poll_stall) || (result_valid && !result_stall) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
				pending_results.size());
			$display("two_line_exchange_controller_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		poll_valid = 1'b0;
		poll = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				wait_drained();
				write_register(dir_rows[i].idx, dir_rows[i].value);
			end else begin
				send_poll(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			idle_on = (phase != PHASES - 1);
			write_register(REG_SEIZE_DELAY, phase_reg_value(phase, REG_SEIZE_DELAY));
			write_register(REG_RELEASE_GUARD, phase_reg_value(phase, REG_RELEASE_GUARD));
			write_register(REG_RING_ON_TIME, phase_reg_value(phase, REG_RING_ON_TIME));
			write_register(REG_RING_PERIOD, phase_reg_value(phase, REG_RING_PERIOD));
			write_register(REG_POLARITY_HALF, phase_reg_value(phase, REG_POLARITY_HALF));
			if (phase == PH_PRESSURE)
				long_hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				send_poll(user_poll(), 1'b0, '0);
		end
		wait_drained();

		$display("%0d polls sent, %0d results checked, %0d register writes",
			polls_sent, results_checked, reg_writes);
		$display("exchange state codes seen (bit per code): %b", states_seen);
		if (mismatch_count == 0) begin
			$display("two_line_exchange_controller_test: PASS");
		end else begin
			$display("two_line_exchange_controller_test: FAIL");
		end
		$finish;
	end

endmodule
